### hdl/tcl_pkg.sv
// shared types, constants and coefficient table for the thermocouple converter
package tcl_pkg;

    localparam int FRAC_BITS_DEF   = 40;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CODE_W     = 24;
    localparam int CJ_W       = 16;
    localparam int TEMP_W     = 16;
    localparam int REF_W      = 13;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int NUM_W      = CODE_W + REF_W;
    localparam int DEN_W      = 41;
    localparam int REM_W      = DEN_W + 1;
    localparam int POLY_ORDER = 8;
    localparam int ACC_FRAC   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_IDX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_IDX = 2'd1;

    localparam logic [REF_W-1:0]  REF_RESET  = 13'd2048;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd64;

    // full-scale code times millivolts per volt
    localparam logic [32:0] DEN_UNIT = 33'd8388607000;

    // cold-junction voltage coefficients, 64 fractional bits
    localparam logic signed [63:0] CJ_C2 = 64'sd34679860;
    localparam logic signed [63:0] CJ_C1 = 64'sd7289822332565;
    localparam logic signed [63:0] CJ_C0 = 64'sd15268674441087;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7fff;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

    typedef struct packed {
        logic [NUM_W-1:0]        num;
        logic [DEN_W-1:0]        den;
        logic                    neg;
        logic signed [CJ_W-1:0]  cj;
    } t_fe_item;

    typedef struct packed {
        logic vld;
        logic neg;
        logic outside;
    } t_ctl;

    // inverse polynomial coefficients, 16 fractional bits
    function automatic logic signed [63:0] poly_coef(input int k);
        logic signed [63:0] c;
        case (k)
            0:       c = 64'sd14849;
            1:       c = 64'sd1582832615;
            2:       c = 64'sd4406209728;
            3:       c = 64'sd144856886936;
            4:       c = -64'sd56424131126886;
            5:       c = 64'sd3168704921600000;
            6:       c = -64'sd77628702720000000;
            7:       c = 64'sd908918784000000000;
            8:       c = -64'sd4153068748800000000;
            default: c = 64'sd0;
        endcase
        return c;
    endfunction

endpackage

### hdl/tcl_front.sv
// front end: takes an item, forms magnitude, numerator and denominator
module tcl_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [tcl_pkg::CODE_W-1:0]           i_adc_code,
    input  logic signed [tcl_pkg::CJ_W-1:0]      i_junction_temp_centi,
    input  logic [tcl_pkg::REF_W-1:0]            i_ref_mv,
    input  logic [tcl_pkg::GAIN_W-1:0]           i_gain,
    output logic                                 o_push,
    output tcl_pkg::t_fe_item                    o_item
);

    logic                               r_vld;
    logic [tcl_pkg::CODE_W-1:0]         r_mag;
    logic                               r_neg;
    logic signed [tcl_pkg::CJ_W-1:0]    r_cj;
    logic [tcl_pkg::GAIN_W-1:0]         gain_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    // one's complement magnitude for negative codes
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_neg <= i_adc_code[tcl_pkg::CODE_W-1];
            r_mag <= i_adc_code[tcl_pkg::CODE_W-1] ? ~i_adc_code : i_adc_code;
            r_cj  <= i_junction_temp_centi;
        end
    end

    always_comb begin
        gain_eff     = (i_gain == '0) ? tcl_pkg::GAIN_W'(1) : i_gain;
        o_push       = r_vld;
        o_item.num   = tcl_pkg::NUM_W'(r_mag) * tcl_pkg::NUM_W'(i_ref_mv);
        o_item.den   = tcl_pkg::DEN_W'(tcl_pkg::DEN_UNIT) * tcl_pkg::DEN_W'(gain_eff);
        o_item.neg   = r_neg;
        o_item.cj    = r_cj;
    end

endmodule

### hdl/tcl_queue.sv
// short item queue between the front end and the arithmetic back end
module tcl_queue #(
    parameter int DEPTH = tcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcl_pkg::t_fe_item i_item,
    output logic              o_vld,
    output tcl_pkg::t_fe_item o_item,
    output logic              o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcl_pkg::t_fe_item r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              pop;

    // the back end never stalls, so the head leaves whenever present
    assign pop    = (r_cnt != '0);
    assign o_vld  = pop;
    assign o_item = r_mem[r_rptr];
    assign o_full = (r_cnt >= CNT_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/tcl_div.sv
// pipelined restoring divider: one quotient bit of the voltage per stage
module tcl_div #(
    parameter int FRAC_BITS = tcl_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  tcl_pkg::t_fe_item                 i_item,
    output tcl_pkg::t_ctl                     o_ctl,
    output logic [FRAC_BITS-1:0]              o_v,
    output logic signed [tcl_pkg::CJ_W-1:0]   o_cj_tap
);

    localparam int RW = tcl_pkg::REM_W;
    localparam int CJ_TAP = FRAC_BITS - 3;

    logic                             r_vld [0:FRAC_BITS];
    logic                             r_neg [0:FRAC_BITS];
    logic                             r_out [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]             r_q   [0:FRAC_BITS];
    logic [RW-1:0]                    r_rem [0:FRAC_BITS-1];
    logic [tcl_pkg::DEN_W-1:0]        r_den [0:FRAC_BITS-1];
    logic signed [tcl_pkg::CJ_W-1:0]  r_cj  [0:CJ_TAP];

    logic [RW-1:0]                    n_sh  [0:FRAC_BITS-1];
    logic                             n_ge  [0:FRAC_BITS-1];
    logic [RW-1:0]                    n_rem [0:FRAC_BITS-2];
    logic [FRAC_BITS-1:0]             n_q   [0:FRAC_BITS-1];

    always_comb begin
        for (int k = 0; k < FRAC_BITS; k++) begin
            n_sh[k] = {r_rem[k][RW-2:0], 1'b0};
            n_ge[k] = (n_sh[k] >= RW'(r_den[k]));
            n_q[k]  = {r_q[k][FRAC_BITS-2:0], n_ge[k]};
        end
        for (int k = 0; k < FRAC_BITS - 1; k++) begin
            n_rem[k] = n_ge[k] ? (n_sh[k] - RW'(r_den[k])) : n_sh[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FRAC_BITS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < FRAC_BITS; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // a voltage of one volt or more cannot be evaluated
        r_rem[0] <= RW'(i_item.num);
        r_den[0] <= i_item.den;
        r_q[0]   <= '0;
        r_neg[0] <= i_item.neg;
        r_out[0] <= (tcl_pkg::DEN_W'(i_item.num) >= i_item.den);
        r_cj[0]  <= i_item.cj;
        for (int k = 0; k < FRAC_BITS; k++) begin
            r_q[k+1]   <= n_q[k];
            r_neg[k+1] <= r_neg[k];
            r_out[k+1] <= r_out[k];
        end
        for (int k = 0; k < FRAC_BITS - 1; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_den[k+1] <= r_den[k];
        end
        for (int k = 0; k < CJ_TAP; k++) begin
            r_cj[k+1] <= r_cj[k];
        end
    end

    assign o_ctl    = '{vld: r_vld[FRAC_BITS], neg: r_neg[FRAC_BITS], outside: r_out[FRAC_BITS]};
    assign o_v      = r_q[FRAC_BITS];
    assign o_cj_tap = r_cj[CJ_TAP];

endmodule

### hdl/tcl_cj.sv
// three-stage cold-junction voltage, aligned with the divider output
module tcl_cj #(
    parameter int FRAC_BITS = tcl_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic signed [tcl_pkg::CJ_W-1:0]   i_cj,
    output logic signed [FRAC_BITS+1:0]       o_t
);

    localparam int WW    = FRAC_BITS + 2;
    localparam int SHIFT = 64 - FRAC_BITS;

    logic signed [31:0] r_ee;
    logic signed [63:0] r_c1e;
    logic signed [63:0] r_c2ee;
    logic signed [63:0] r_c1e0;
    logic signed [WW-1:0] r_t;
    logic signed [63:0] acc;

    assign acc = r_c2ee + r_c1e0;

    always_ff @(posedge i_clk) begin
        r_ee   <= 32'(i_cj) * 32'(i_cj);
        r_c1e  <= tcl_pkg::CJ_C1 * 64'(i_cj);
        r_c2ee <= tcl_pkg::CJ_C2 * 64'(r_ee);
        r_c1e0 <= r_c1e + tcl_pkg::CJ_C0;
        // arithmetic shift rounds toward minus infinity
        r_t    <= WW'(acc >>> SHIFT);
    end

    assign o_t = r_t;

endmodule

### hdl/tcl_horner.sv
// compensation, pipelined horner evaluation and output scaling
module tcl_horner #(
    parameter int FRAC_BITS = tcl_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcl_pkg::t_ctl                       i_ctl,
    input  logic [FRAC_BITS-1:0]                i_v,
    input  logic signed [FRAC_BITS+1:0]         i_t,
    output logic                                o_valid,
    output logic signed [tcl_pkg::TEMP_W-1:0]   o_temperature_tenths
);

    localparam int WW = FRAC_BITS + 2;
    localparam int NS = tcl_pkg::POLY_ORDER;
    localparam logic signed [WW-1:0] W_LIM = WW'(64'd1 << (FRAC_BITS - 1));

    logic signed [WW-1:0]  v_ext;
    logic signed [WW-1:0]  w_n;
    logic                  out_n;
    logic signed [WW-1:0]  r_w;
    tcl_pkg::t_ctl         r_ctl;

    wire signed [63:0]     h_s   [0:NS];
    wire signed [WW-1:0]   w_s   [0:NS-1];
    wire tcl_pkg::t_ctl    ctl_s [0:NS];

    always_comb begin
        v_ext = $signed({2'b00, i_v});
        w_n   = i_ctl.neg ? (v_ext - i_t) : (v_ext + i_t);
        out_n = i_ctl.outside | (w_n >= W_LIM) | (w_n <= -W_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= '{vld: i_ctl.vld, neg: i_ctl.neg, outside: out_n};
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= w_n;
    end

    assign h_s[0]   = tcl_pkg::poly_coef(NS);
    assign w_s[0]   = r_w;
    assign ctl_s[0] = r_ctl;

    // each step: magnitudes, partial products, sum, sign and coefficient add
    for (genvar s = 0; s < NS; s++) begin : g_step
        logic [WW-1:0]          aw_n;
        logic signed [127:0]    sp_n;
        logic [63:0]            r_ah;
        logic [63:0]            r_aw;
        logic                   r_sa;
        logic signed [WW-1:0]   r_wa;
        tcl_pkg::t_ctl          r_ca;
        logic [63:0]            r_p00;
        logic [63:0]            r_p01;
        logic [63:0]            r_p10;
        logic [63:0]            r_p11;
        logic                   r_sb;
        logic signed [WW-1:0]   r_wb;
        tcl_pkg::t_ctl          r_cb;
        logic [127:0]           r_p;
        logic                   r_sc;
        logic signed [WW-1:0]   r_wc;
        tcl_pkg::t_ctl          r_cc;
        logic signed [63:0]     r_h;
        tcl_pkg::t_ctl          r_cd;

        always_comb begin
            aw_n = w_s[s][WW-1] ? WW'(-w_s[s]) : WW'(w_s[s]);
            sp_n = r_sc ? -$signed(r_p) : $signed(r_p);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ca <= '0;
                r_cb <= '0;
                r_cc <= '0;
                r_cd <= '0;
            end else begin
                r_ca <= ctl_s[s];
                r_cb <= r_ca;
                r_cc <= r_cb;
                r_cd <= r_cc;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ah  <= h_s[s][63] ? 64'(-h_s[s]) : 64'(h_s[s]);
            r_aw  <= 64'(aw_n);
            r_sa  <= h_s[s][63] ^ w_s[s][WW-1];
            r_wa  <= w_s[s];
            r_p00 <= 64'(r_ah[31:0])  * 64'(r_aw[31:0]);
            r_p01 <= 64'(r_ah[31:0])  * 64'(r_aw[63:32]);
            r_p10 <= 64'(r_ah[63:32]) * 64'(r_aw[31:0]);
            r_p11 <= 64'(r_ah[63:32]) * 64'(r_aw[63:32]);
            r_sb  <= r_sa;
            r_wb  <= r_wa;
            r_p   <= 128'(r_p00) + (128'(r_p01) << 32) + (128'(r_p10) << 32)
                     + (128'(r_p11) << 64);
            r_sc  <= r_sb;
            r_wc  <= r_wb;
            r_h   <= 64'(sp_n >>> FRAC_BITS) + tcl_pkg::poly_coef(NS - 1 - s);
        end

        if (s < NS - 1) begin : g_wpass
            logic signed [WW-1:0] r_wd;
            always_ff @(posedge i_clk) begin
                r_wd <= r_wc;
            end
            assign w_s[s+1] = r_wd;
        end

        assign h_s[s+1]   = r_h;
        assign ctl_s[s+1] = r_cd;
    end

    // scale to tenths, truncate toward zero and saturate
    logic signed [67:0] h10;
    logic signed [67:0] xb;
    logic signed [67:0] q;
    logic signed [67:0] r_x;
    tcl_pkg::t_ctl      r_cx;
    logic               r_valid;
    logic signed [tcl_pkg::TEMP_W-1:0] r_temp;

    always_comb begin
        h10 = (68'(h_s[NS]) <<< 3) + (68'(h_s[NS]) <<< 1);
        xb  = r_x + (r_x[67] ? 68'sd65535 : 68'sd0);
        q   = xb >>> tcl_pkg::ACC_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cx    <= ctl_s[NS];
            r_valid <= r_cx.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= ctl_s[NS].neg ? -h10 : h10;
        if (r_cx.outside) begin
            r_temp <= r_cx.neg ? tcl_pkg::TEMP_MAX : tcl_pkg::TEMP_MIN;
        end else if (q > 68'sd32767) begin
            r_temp <= tcl_pkg::TEMP_MAX;
        end else if (q < -68'sd32768) begin
            r_temp <= tcl_pkg::TEMP_MIN;
        end else begin
            r_temp <= q[tcl_pkg::TEMP_W-1:0];
        end
    end

    assign o_valid              = r_valid;
    assign o_temperature_tenths = r_temp;

endmodule

### hdl/thermocouple_code_to_temperature_unit.sv
// top level: type k thermocouple code to hot-junction temperature converter
//
// Takes one converter code per clock cycle while busy is low and returns one
// temperature per item, in item order, through the divider, which forms one
// voltage bit per pipeline stage, and the eight horner steps of four stages
// each. o_valid is high for exactly one cycle per result and the receiver
// must take it then. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and should only change while no item is in flight.
module thermocouple_code_to_temperature_unit #(
    parameter int FRAC_BITS   = tcl_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = tcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [tcl_pkg::CODE_W-1:0]           i_adc_code,
    input  logic signed [tcl_pkg::CJ_W-1:0]      i_junction_temp_centi,
    output logic                                 o_valid,
    output logic signed [tcl_pkg::TEMP_W-1:0]    o_temperature_tenths,
    input  logic                                 i_cfg_we,
    input  logic [tcl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tcl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [tcl_pkg::REF_W-1:0]          r_ref_mv;
    logic [tcl_pkg::GAIN_W-1:0]         r_gain;
    logic                               accept;
    logic                               fe_push;
    tcl_pkg::t_fe_item                  fe_item;
    logic                               q_vld;
    tcl_pkg::t_fe_item                  q_item;
    logic                               q_full;
    tcl_pkg::t_ctl                      div_ctl;
    logic [FRAC_BITS-1:0]               div_v;
    logic signed [tcl_pkg::CJ_W-1:0]    cj_tap;
    logic signed [FRAC_BITS+1:0]        cj_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv <= tcl_pkg::REF_RESET;
            r_gain   <= tcl_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcl_pkg::CFG_REF_IDX:  r_ref_mv <= i_cfg_data[tcl_pkg::REF_W-1:0];
                tcl_pkg::CFG_GAIN_IDX: r_gain   <= i_cfg_data[tcl_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    tcl_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_accept              (accept),
        .i_adc_code            (i_adc_code),
        .i_junction_temp_centi (i_junction_temp_centi),
        .i_ref_mv              (r_ref_mv),
        .i_gain                (r_gain),
        .o_push                (fe_push),
        .o_item                (fe_item)
    );

    tcl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_item  (fe_item),
        .o_vld   (q_vld),
        .o_item  (q_item),
        .o_full  (q_full)
    );

    tcl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .i_item   (q_item),
        .o_ctl    (div_ctl),
        .o_v      (div_v),
        .o_cj_tap (cj_tap)
    );

    tcl_cj #(.FRAC_BITS(FRAC_BITS)) u_cj (
        .i_clk (i_clk),
        .i_cj  (cj_tap),
        .o_t   (cj_t)
    );

    tcl_horner #(.FRAC_BITS(FRAC_BITS)) u_horner (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (div_ctl),
        .i_v                  (div_v),
        .i_t                  (cj_t),
        .o_valid              (o_valid),
        .o_temperature_tenths (o_temperature_tenths)
    );

endmodule

### tb/thermocouple_code_to_temperature_unit_test.sv
// testbench for the thermocouple code to temperature converter
`timescale 1ns / 1ps

class temperature_scoreboard;
    localparam int VFRAC = 40;

    logic [12:0]        ref_mv;
    logic [7:0]         gain;
    logic signed [15:0] pending_temps[$];
    int                 mismatches;

    function new();
        ref_mv = tcl_pkg::REF_RESET;
        gain = tcl_pkg::GAIN_RESET;
        mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] data);
        if (idx == tcl_pkg::CFG_REF_IDX) ref_mv = data;
        else if (idx == tcl_pkg::CFG_GAIN_IDX) gain = data[7:0];
    endfunction

    // floor(a * b / 2^VFRAC), saturated on magnitude
    function automatic logic signed [63:0] fixed_product(logic signed [63:0] a,
                                                         logic signed [63:0] b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [127:0] q;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        q = p >> VFRAC;
        if (neg && p[VFRAC-1:0] != 0) q = q + 1;
        if (q > 128'h7fff_ffff_ffff_ffff) q = 128'h7fff_ffff_ffff_ffff;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [15:0] hot_junction(logic [23:0] code,
                                                       logic signed [15:0] cj);
        logic signed [63:0] coef[9];
        logic [23:0]        mag;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [127:0]       volts;
        logic signed [63:0] e;
        logic signed [63:0] comp;
        logic signed [63:0] w;
        logic signed [63:0] h;
        logic signed [63:0] tenths;
        bit                 neg;
        coef[0] = 64'sd14849;
        coef[1] = 64'sd1582832615;
        coef[2] = 64'sd4406209728;
        coef[3] = 64'sd144856886936;
        coef[4] = -64'sd56424131126886;
        coef[5] = 64'sd3168704921600000;
        coef[6] = -64'sd77628702720000000;
        coef[7] = 64'sd908918784000000000;
        coef[8] = -64'sd4153068748800000000;
        neg = code[23];
        mag = neg ? ~code : code;
        num = 64'(mag) * 64'(ref_mv);
        den = 64'd8388607 * 64'((gain == 0) ? 8'd1 : gain) * 64'd1000;
        if (num >= den) return neg ? 16'sh7fff : 16'sh8000;
        volts = {num, 40'd0} / {64'd0, den};
        e = cj;
        comp = (64'sd34679860 * e * e + 64'sd7289822332565 * e + 64'sd15268674441087)
               >>> (64 - VFRAC);
        w = neg ? $signed(volts[63:0]) - comp : $signed(volts[63:0]) + comp;
        // outside the polynomial domain the leading term runs away negative
        if (w >= (64'sd1 <<< (VFRAC - 1)) || w <= -(64'sd1 <<< (VFRAC - 1)))
            return neg ? 16'sh7fff : 16'sh8000;
        h = coef[8];
        for (int i = 7; i >= 0; i--) h = fixed_product(h, w) + coef[i];
        h = h * 10;
        if (neg) h = -h;
        tenths = h / 64'sd65536;
        if (tenths > 32767) tenths = 32767;
        if (tenths < -32768) tenths = -32768;
        return tenths[15:0];
    endfunction

    function void note_item(logic [23:0] code, logic signed [15:0] cj);
        pending_temps.push_back(hot_junction(code, cj));
    endfunction

    function void check_result(logic signed [15:0] got);
        logic signed [15:0] want;
        if (pending_temps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", got);
            return;
        end
        want = pending_temps.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("temperature mismatch: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module thermocouple_code_to_temperature_unit_test;

    localparam int CYCLE_LIMIT = 300000;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic [tcl_pkg::CODE_W-1:0]           i_adc_code;
    logic signed [tcl_pkg::CJ_W-1:0]      i_junction_temp_centi;
    logic                                 o_valid;
    logic signed [tcl_pkg::TEMP_W-1:0]    o_temperature_tenths;
    logic                                 i_cfg_we;
    logic [tcl_pkg::CFG_IDX_W-1:0]        i_cfg_idx;
    logic [tcl_pkg::CFG_DATA_W-1:0]       i_cfg_data;

    temperature_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 0;

    thermocouple_code_to_temperature_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_valid) sb.check_result(o_temperature_tenths);
    end

    task automatic send_item(logic [23:0] code, logic signed [15:0] cj);
        start <= 1'b1;
        i_adc_code <= code;
        i_junction_temp_centi <= cj;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_item(code, cj);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_temps.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // mostly codes inside the working range, some raw noise
    task automatic random_item();
        logic [63:0]        span;
        logic [23:0]        mag;
        logic signed [15:0] cj;
        logic [7:0]         g;
        g = (sb.gain == 0) ? 8'd1 : sb.gain;
        if ($urandom_range(0, 9) < 7) begin
            span = (64'd8388607 * g * 64'd40) / ((sb.ref_mv == 0) ? 64'd1 : sb.ref_mv);
            if (span > 64'h7fffff) span = 64'h7fffff;
            mag = 24'($urandom_range(0, span[31:0]));
            cj = 16'($urandom_range(0, 8000) - 2000);
            send_item($urandom_range(0, 1) ? ~mag : mag, cj);
        end else begin
            send_item(24'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [12:0] refs[7];
        logic [12:0] gains[7];
        refs  = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd2500, 13'd1234, 13'd2048};
        gains = '{13'd128, 13'd1, 13'd0, 13'd255, 13'd32, 13'd7, 13'd64};
        i_rst_n = 0;
        start = 0;
        i_adc_code = 0;
        i_junction_temp_centi = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, full scale both signs, all-ones code, junction extremes
        send_item(24'h000000, 16'sd0);
        send_item(24'h7fffff, 16'sd0);
        send_item(24'h800000, 16'sd0);
        send_item(24'hffffff, 16'sd0);
        send_item(24'hffffff, 16'sd2500);
        send_item(24'h000001, 16'sd2500);
        send_item(24'hfffffe, -16'sd1000);
        send_item(24'd5400000, 16'sd0);
        send_item(~24'd5400000, 16'sd0);
        send_item(24'd2700000, 16'sd2200);
        send_item(~24'd1000000, 16'sd2200);
        send_item(24'd1000, 16'sh7fff);
        send_item(24'd1000, 16'sh8000);
        send_item(~24'd1000, 16'sh7fff);
        send_item(~24'd1000, 16'sh8000);
        send_item(24'd8000000, 16'sh7fff);
        send_item(24'h555555, 16'sh5555);
        send_item(24'haaaaaa, 16'shaaaa);
        drain();

        // unknown indexes must not disturb anything
        write_reg(2'd2, 13'h1fff);
        write_reg(2'd3, 13'h0000);
        send_item(24'd3000000, 16'sd2000);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_reg(tcl_pkg::CFG_REF_IDX, refs[ph]);
            write_reg(tcl_pkg::CFG_GAIN_IDX, gains[ph]);
            quiet = (ph == 6);
            for (int n = 0; n < 190; n++) random_item();
        end
        drain();
        if (sb.pending_temps.size() != 0) sb.mismatches++;
        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
